FILE: sv/gtc_pkg.sv
// Shared types and constants for the graph transitive closure block.
// Used by gtc_row_mem, gtc_sweep and graph_transitive_closure; no dependencies.
package gtc_pkg;

	localparam int ROW_W = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_PIVOT = 4'b0010,
		ST_ROWS  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	// kind of memory read in flight
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_PIVOT = 2'd1,
		OP_ROW   = 2'd2,
		OP_EMIT  = 2'd3
	} op_t;

	// closure row handed from the sequencer to the output register
	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		logic [IDX_W-1:0] index;
		logic             last;
	} emit_t;

endpackage

FILE: sv/graph_transitive_closure.sv
// Reflexive transitive closure of a directed graph of up to 32 vertices.
// Input channel (in_valid/in_ready, edge_row): one adjacency row per request,
// row 0 first; bits at or above the vertex count are ignored.
// Output channel (out_valid/out_ready, reach_row, row_index, last_row): one
// closure row per vertex in vertex order, last_row high on the final one.
// Configuration: cfg_we/cfg_data write vertex_count (0 acts as 1, values above
// the store depth saturate) and discard rows already loaded.
// Closure work runs one pass per pivot: a pivot read, then a read-modify-write
// of every row (written back only where it reaches the pivot), limited by the
// single read port of the row store; readout then reads one row at a time.
// The block takes no input during closure work or readout, and takes the
// next graph's rows while the final output row still waits.
// A stalled receiver holds the output register and pauses readout.
// Reset sets vertex_count to 32 and empties the load count; the row store
// needs no clearing, since every row is written before it is read.
// Depends on gtc_pkg, gtc_row_mem and gtc_sweep.
module graph_transitive_closure #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [gtc_pkg::CNT_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [gtc_pkg::ROW_W-1:0]  edge_row,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [gtc_pkg::ROW_W-1:0]  reach_row,
	output logic [gtc_pkg::IDX_W-1:0]  row_index,
	output logic                       last_row
);

	localparam int DEPTH = (MAX_VERTICES < gtc_pkg::ROW_W) ? MAX_VERTICES : gtc_pkg::ROW_W;
	localparam int AW    = $clog2(DEPTH);

	logic [gtc_pkg::CNT_W-1:0] vertex_count_q;
	logic [AW-1:0]             last_idx;
	logic [gtc_pkg::ROW_W-1:0] col_mask;
	logic                      mem_wr_en;
	logic [AW-1:0]             mem_wr_addr;
	logic [gtc_pkg::ROW_W-1:0] mem_wr_data;
	logic                      mem_rd_en;
	logic [AW-1:0]             mem_rd_addr;
	logic [gtc_pkg::ROW_W-1:0] mem_rd_data;
	gtc_pkg::emit_t            emit;
	logic                      out_valid_q;
	logic [gtc_pkg::ROW_W-1:0] reach_row_q;
	logic [gtc_pkg::IDX_W-1:0] row_index_q;
	logic                      last_row_q;

	// hold the vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= gtc_pkg::CNT_W'(32);
		end else if (cfg_we) begin
			vertex_count_q <= cfg_data;
		end
	end

	// clamp the count and derive the last vertex index
	always_comb begin
		if (vertex_count_q == '0) begin
			last_idx = '0;
		end else if (vertex_count_q > gtc_pkg::CNT_W'(DEPTH)) begin
			last_idx = AW'(DEPTH - 1);
		end else begin
			last_idx = AW'(vertex_count_q - gtc_pkg::CNT_W'(1));
		end
	end

	// keep only columns of active vertices
	always_comb begin
		for (int j = 0; j < gtc_pkg::ROW_W; j++) begin
			col_mask[j] = (32'(j) <= 32'(last_idx));
		end
	end

	gtc_row_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	gtc_sweep #(
		.AW(AW)
	) u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_clear  (cfg_we),
		.last_idx   (last_idx),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_row     (edge_row & col_mask),
		.out_free   (!out_valid_q || out_ready),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.emit       (emit)
	);

	// hold each closure row until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			reach_row_q <= emit.row;
			row_index_q <= emit.index;
			last_row_q  <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign reach_row = reach_row_q;
	assign row_index = row_index_q;
	assign last_row  = last_row_q;

endmodule

FILE: sv/gtc_row_mem.sv
// Row store: one write port, one read port, registered read data.
// Depends on gtc_pkg for the row width.
module gtc_row_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [gtc_pkg::ROW_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [gtc_pkg::ROW_W-1:0] rd_data
);

	logic [gtc_pkg::ROW_W-1:0] mem_q [DEPTH];
	logic [gtc_pkg::ROW_W-1:0] rd_data_q;

	// write, then read old contents on an address match
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/gtc_sweep.sv
// Sequencer: loads rows, runs one read-modify-write pass per pivot over the
// row store, then reads the closure rows out. Depends on gtc_pkg.
module gtc_sweep #(
	parameter int AW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_clear,
	input  logic [AW-1:0]             last_idx,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [gtc_pkg::ROW_W-1:0] in_row,
	input  logic                      out_free,
	output logic                      mem_wr_en,
	output logic [AW-1:0]             mem_wr_addr,
	output logic [gtc_pkg::ROW_W-1:0] mem_wr_data,
	output logic                      mem_rd_en,
	output logic [AW-1:0]             mem_rd_addr,
	input  logic [gtc_pkg::ROW_W-1:0] mem_rd_data,
	output gtc_pkg::emit_t            emit
);

	gtc_pkg::state_t state_q;
	gtc_pkg::op_t    rd_op;
	gtc_pkg::op_t    op_s1;

	logic [AW-1:0]             load_q;
	logic [AW-1:0]             k_q;
	logic [AW-1:0]             i_q;
	logic [AW-1:0]             addr_s1;
	logic                      fwd_s1;
	logic [gtc_pkg::ROW_W-1:0] fwd_data_s1;
	logic [gtc_pkg::ROW_W-1:0] pivot_q;
	logic [AW-1:0]             pivot_idx_q;
	logic [gtc_pkg::ROW_W-1:0] rd_row;
	logic                      load_we;
	logic                      row_we;
	logic                      emit_go;

	// issue reads and take input rows by state
	assign emit_go = out_free && (op_s1 != gtc_pkg::OP_EMIT);

	always_comb begin
		in_ready    = 1'b0;
		load_we     = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = i_q;
		rd_op       = gtc_pkg::OP_NONE;
		unique case (state_q)
			gtc_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				load_we  = in_valid;
			end
			gtc_pkg::ST_PIVOT: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = k_q;
				rd_op       = gtc_pkg::OP_PIVOT;
			end
			gtc_pkg::ST_ROWS: begin
				mem_rd_en = 1'b1;
				rd_op     = gtc_pkg::OP_ROW;
			end
			gtc_pkg::ST_EMIT: begin
				if (emit_go) begin
					mem_rd_en = 1'b1;
					rd_op     = gtc_pkg::OP_EMIT;
				end
			end
			default: ;
		endcase
	end

	// forward a row written in the cycle it was read
	assign rd_row = fwd_s1 ? fwd_data_s1 : mem_rd_data;

	// merge the pivot row into every row that reaches the pivot
	assign row_we = (op_s1 == gtc_pkg::OP_ROW) && rd_row[pivot_idx_q];

	always_comb begin
		mem_wr_en = load_we || row_we;
		if (row_we) begin
			mem_wr_addr = addr_s1;
			mem_wr_data = rd_row | pivot_q;
		end else begin
			mem_wr_addr = load_q;
			mem_wr_data = in_row | (gtc_pkg::ROW_W'(1) << load_q);
		end
	end

	// sequence load, pivot passes and readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtc_pkg::ST_LOAD;
			load_q  <= '0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				gtc_pkg::ST_LOAD: begin
					if (in_valid) begin
						if (load_q == last_idx) begin
							load_q  <= '0;
							k_q     <= '0;
							state_q <= gtc_pkg::ST_PIVOT;
						end else begin
							load_q <= load_q + AW'(1);
						end
					end
				end
				gtc_pkg::ST_PIVOT: begin
					i_q     <= '0;
					state_q <= gtc_pkg::ST_ROWS;
				end
				gtc_pkg::ST_ROWS: begin
					if (i_q == last_idx) begin
						i_q <= '0;
						if (k_q == last_idx) begin
							state_q <= gtc_pkg::ST_EMIT;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= gtc_pkg::ST_PIVOT;
						end
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
				gtc_pkg::ST_EMIT: begin
					if (emit_go) begin
						if (i_q == last_idx) begin
							i_q     <= '0;
							state_q <= gtc_pkg::ST_LOAD;
						end else begin
							i_q <= i_q + AW'(1);
						end
					end
				end
				default: state_q <= gtc_pkg::ST_LOAD;
			endcase
			// drop partly loaded rows on a count write
			if (cfg_clear) begin
				load_q <= '0;
			end
		end
	end

	// track the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= gtc_pkg::OP_NONE;
			fwd_s1 <= 1'b0;
		end else begin
			op_s1  <= rd_op;
			fwd_s1 <= mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= mem_rd_addr;
		fwd_data_s1 <= mem_wr_data;
		if (op_s1 == gtc_pkg::OP_PIVOT) begin
			pivot_q     <= rd_row;
			pivot_idx_q <= addr_s1;
		end
	end

	// hand the closure row to the output register
	always_comb begin
		emit.valid = (op_s1 == gtc_pkg::OP_EMIT);
		emit.row   = rd_row;
		emit.index = gtc_pkg::IDX_W'(addr_s1);
		emit.last  = (addr_s1 == last_idx);
	end

endmodule

FILE: tb/tb_graph_transitive_closure.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_transitive_closure: a scoreboard class predicts
// each closure row from the accepted adjacency rows and the vertex count.
// Depends on gtc_pkg and the graph_transitive_closure RTL.

typedef struct packed {
	logic [gtc_pkg::ROW_W-1:0] reach;
	logic [gtc_pkg::IDX_W-1:0] vertex;
	logic                      last;
} closure_row_t;

class closure_scoreboard;
	localparam int unsigned DEPTH = 32;

	logic [gtc_pkg::ROW_W-1:0] adjacency [DEPTH];
	logic [gtc_pkg::CNT_W-1:0] vertex_count;
	int unsigned               rows_held;
	closure_row_t              closure_q [$];
	int unsigned               errors;

	function new();
		vertex_count = 6'd32;
		rows_held    = 0;
		errors       = 0;
	endfunction

	// zero acts as one, anything past the store depth saturates
	function int unsigned active_count();
		int unsigned n;
		n = vertex_count;
		if (n < 1)
			n = 1;
		if (n > DEPTH)
			n = DEPTH;
		return n;
	endfunction

	function logic [gtc_pkg::ROW_W-1:0] row_mask();
		logic [63:0] m;
		m = (64'd1 << active_count()) - 64'd1;
		return m[gtc_pkg::ROW_W-1:0];
	endfunction

	// a count write drops any partly loaded graph
	function void write_count(logic [gtc_pkg::CNT_W-1:0] value);
		vertex_count = value;
		rows_held    = 0;
	endfunction

	function int unsigned pending();
		return closure_q.size();
	endfunction

	// note an accepted request; a completed graph queues its closure rows
	function void note_row(logic [gtc_pkg::ROW_W-1:0] edges);
		logic [gtc_pkg::ROW_W-1:0] mask;
		logic [gtc_pkg::ROW_W-1:0] reach [DEPTH];
		closure_row_t              item;
		int unsigned               n;
		n    = active_count();
		mask = row_mask();
		if (rows_held >= n)
			rows_held = 0;
		adjacency[rows_held] = edges & mask;
		rows_held++;
		if (rows_held < n)
			return;
		rows_held = 0;
		// seed with self reachability, then fold in each pivot vertex in turn
		for (int unsigned i = 0; i < n; i++)
			reach[i] = adjacency[i] | (32'd1 << i);
		for (int unsigned k = 0; k < n; k++)
			for (int unsigned i = 0; i < n; i++)
				if (reach[i][k])
					reach[i] = reach[i] | reach[k];
		for (int unsigned i = 0; i < n; i++) begin
			item.reach  = reach[i] & mask;
			item.vertex = i[gtc_pkg::IDX_W-1:0];
			item.last   = (i + 1 == n);
			closure_q.push_back(item);
		end
	endfunction

	// compare one accepted closure row with the oldest prediction
	function void check_row(logic [gtc_pkg::ROW_W-1:0] reach, logic [gtc_pkg::IDX_W-1:0] vertex,
			logic last);
		closure_row_t want;
		if (closure_q.size() == 0) begin
			$error("unexpected closure row: reach_row %h row_index %0d last_row %0d",
				reach, vertex, last);
			errors++;
			return;
		end
		want = closure_q.pop_front();
		if (reach !== want.reach) begin
			$error("reach_row: expected %h, actual %h", want.reach, reach);
			errors++;
		end
		if (vertex !== want.vertex) begin
			$error("row_index: expected %0d, actual %0d", want.vertex, vertex);
			errors++;
		end
		if (last !== want.last) begin
			$error("last_row: expected %0d, actual %0d", want.last, last);
			errors++;
		end
	endfunction

	function void check_drained();
		if (closure_q.size() != 0) begin
			$error("%0d closure rows never arrived", closure_q.size());
			errors++;
		end
	endfunction
endclass

module tb_graph_transitive_closure;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned TAIL        = 64;
	localparam int unsigned RANDOM_ROWS = 150;

	typedef enum int unsigned {
		FILL_DENSE,
		FILL_SPARSE,
		FILL_THIN
	} row_fill_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [gtc_pkg::CNT_W-1:0] cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [gtc_pkg::ROW_W-1:0] edge_row;
	logic                      out_valid;
	logic                      out_ready;
	logic [gtc_pkg::ROW_W-1:0] reach_row;
	logic [gtc_pkg::IDX_W-1:0] row_index;
	logic                      last_row;

	closure_scoreboard sb;
	bit                drain;
	bit                long_hold_req;
	int unsigned       random_rows;
	int unsigned       cycle_count;

	graph_transitive_closure #(
		.MAX_VERTICES(32)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.edge_row  (edge_row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.reach_row (reach_row),
		.row_index (row_index),
		.last_row  (last_row)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("graph_transitive_closure: mismatch");
			$finish;
		end
	end

	// check every closure row that leaves the block
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_row(reach_row, row_index, last_row);
	end

	// receiver: random stalls, ready stretches, and one long hold on request
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				for (int unsigned c = 0; c < LONG_HOLD; c++)
					@(posedge clk);
			end else if (!drain && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// offer one request, idling first at random; keep valid up for the next one
	task automatic send_row(input logic [gtc_pkg::ROW_W-1:0] edges);
		if (!drain && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		edge_row <= edges;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_row(edges);
	endtask

	// drop valid and hold until every predicted row has come back
	task automatic end_phase();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(input logic [gtc_pkg::CNT_W-1:0] value);
		cfg_data <= value;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
		sb.write_count(value);
	endtask

	function automatic logic [gtc_pkg::ROW_W-1:0] pick_row(row_fill_t fill);
		logic [gtc_pkg::ROW_W-1:0] r;
		case (fill)
			FILL_DENSE:  r = $urandom();
			FILL_SPARSE: r = $urandom() & $urandom() & $urandom();
			default: begin
				// at most one edge in range, noise above the vertex count
				r = $urandom() & ~sb.row_mask();
				if ($urandom_range(0, 1) == 1)
					r[$urandom_range(0, sb.active_count() - 1)] = 1'b1;
			end
		endcase
		return r;
	endfunction

	// whole graphs of random content, sometimes followed by a partial one
	task automatic run_phase(input logic [gtc_pkg::CNT_W-1:0] value,
			input int unsigned graphs, input bit partial, input bit long_hold);
		int unsigned n;
		int unsigned rows;
		row_fill_t   fill;
		set_count(value);
		n    = sb.active_count();
		rows = graphs * n + ((partial && n > 1) ? $urandom_range(1, n - 1) : 0);
		if (long_hold)
			long_hold_req = 1'b1;
		fill = FILL_DENSE;
		for (int unsigned r = 0; r < rows; r++) begin
			if (r % n == 0)
				fill = row_fill_t'($urandom_range(0, 2));
			send_row(pick_row(fill));
			random_rows++;
		end
		end_phase();
	endtask

	initial begin
		sb = new();
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		edge_row <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset count of 32: a path through all vertices
		for (int unsigned i = 0; i < 32; i++)
			send_row(i < 31 ? 32'd1 << (i + 1) : 32'd0);
		end_phase();

		// single vertex, with and without ignored bits; zero count acts as one
		set_count(6'd1);
		send_row(32'h0000_0000);
		send_row(32'hFFFF_FFFF);
		end_phase();
		set_count(6'd0);
		send_row(32'hFFFF_FFFE);
		end_phase();

		// chain 0 -> 1 -> 2, then self loops only
		set_count(6'd3);
		send_row(32'h0000_0002);
		send_row(32'h0000_0004);
		send_row(32'h0000_0000);
		send_row(32'h0000_0001);
		send_row(32'h0000_0002);
		send_row(32'h0000_0004);
		end_phase();

		// count write in the middle of loading discards the partial graph
		set_count(6'd5);
		send_row(32'h0000_001F);
		send_row(32'h0000_0010);
		end_phase();
		set_count(6'd2);
		send_row(32'hFFFF_FFFE);
		send_row(32'h0000_0001);
		end_phase();

		// random graphs: output stalled long enough to back up the input first
		random_rows = 0;
		run_phase(6'd4, 5, 1'b1, 1'b1);
		run_phase(6'd32, 1, 1'b0, 1'b0);
		run_phase(6'd63, 1, 1'b1, 1'b0);
		run_phase(6'd33, 1, 1'b0, 1'b0);
		while (random_rows < RANDOM_ROWS) begin
			if (random_rows > RANDOM_ROWS - 40)
				drain = 1'b1;
			run_phase(gtc_pkg::CNT_W'($urandom_range(0, 5) == 0 ? $urandom_range(9, 16)
				: $urandom_range(2, 8)),
				$urandom_range(1, 3), $urandom_range(0, 1) == 1, 1'b0);
		end

		end_phase();
		repeat (TAIL) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("graph_transitive_closure: match");
		else
			$display("graph_transitive_closure: mismatch");
		$finish;
	end

endmodule

FILE: graph_transitive_closure.f
sv/gtc_pkg.sv
sv/gtc_row_mem.sv
sv/gtc_sweep.sv
sv/graph_transitive_closure.sv
tb/tb_graph_transitive_closure.sv
